>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/esc_pkg.sv
// Types and fixed constants for the expiring status cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned STATUS_OUT_W = 16;

  localparam logic [CFG_W-1:0] EXPIRY_RESET = 16'd30;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control part of the scan token that walks the cell chain.
  typedef struct packed {
    logic  vld;
    mode_e mode;
    logic  found;       // lookup hit or invalidate match seen upstream
    logic  free_found;  // insert: free entry seen upstream
  } scan_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/esc_cell.sv
// One cache entry plus one stage of the scan token chain.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esc_cell import esc_pkg::*; #(
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned STATUS_BITS = 16,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned INDEX       = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [CFG_W-1:0]       expiry_i,
  // token from the upstream neighbour
  input  wire scan_ctrl_t             ctl_i,
  input  wire logic [KEY_BITS-1:0]    key_i,
  input  wire logic [TIME_W-1:0]      now_i,
  input  wire logic [IDX_W-1:0]       slot_i,
  input  wire logic [TIME_W-1:0]      age_i,
  input  wire logic [STATUS_BITS-1:0] st_i,
  // token to the downstream neighbour
  output scan_ctrl_t                  ctl_o,
  output logic [KEY_BITS-1:0]         key_o,
  output logic [TIME_W-1:0]           now_o,
  output logic [IDX_W-1:0]            slot_o,
  output logic [TIME_W-1:0]           age_o,
  output logic [STATUS_BITS-1:0]      st_o,
  // write-back bus
  input  wire logic                   wr_en_i,
  input  wire mode_e                  wr_mode_i,
  input  wire logic [IDX_W-1:0]       wr_slot_i,
  input  wire logic [KEY_BITS-1:0]    wr_key_i,
  input  wire logic [STATUS_BITS-1:0] wr_status_i,
  input  wire logic [TIME_W-1:0]      wr_now_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                   valid_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [STATUS_BITS-1:0] status_q;
  logic [TIME_W-1:0]      stamp_q;

  scan_ctrl_t             ctl_d, ctl_q;
  logic [KEY_BITS-1:0]    tkey_q;
  logic [TIME_W-1:0]      tnow_q;
  logic [IDX_W-1:0]       slot_d, slot_q;
  logic [TIME_W-1:0]      age_d, age_q;
  logic [STATUS_BITS-1:0] st_d, st_q;

  logic [TIME_W-1:0]      age;
  logic                   key_hit;
  logic                   wr_me;

  assign age     = now_i - stamp_q;
  assign key_hit = valid_q && (key_q == key_i);
  assign wr_me   = wr_en_i && (wr_slot_i == MY_IDX);

  always_comb begin
    ctl_d  = ctl_i;
    slot_d = slot_i;
    age_d  = age_i;
    st_d   = st_i;
    if (ctl_i.vld) begin
      unique case (ctl_i.mode)
        MODE_LOOKUP: begin
          if (!ctl_i.found && key_hit && (age < TIME_W'(expiry_i))) begin
            ctl_d.found = 1'b1;
            slot_d      = MY_IDX;
            st_d        = status_q;
          end
        end
        MODE_INSERT: begin
          if (!ctl_i.free_found) begin
            if (!valid_q) begin
              ctl_d.free_found = 1'b1;
              slot_d           = MY_IDX;
            end else if ((INDEX == 0) || (age > age_i)) begin
              // oldest so far; strict compare keeps the lower index on a tie
              slot_d = MY_IDX;
              age_d  = age;
            end
          end
        end
        MODE_INVAL: begin
          if (!ctl_i.found && key_hit) begin
            ctl_d.found = 1'b1;
            slot_d      = MY_IDX;
          end
        end
        default: ;
      endcase
    end
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tkey_q <= key_i;
    tnow_q <= now_i;
    slot_q <= slot_d;
    age_q  <= age_d;
    st_q   <= st_d;
  end

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_me) begin
      unique case (wr_mode_i)
        MODE_INSERT: valid_q <= 1'b1;
        MODE_INVAL:  valid_q <= 1'b0;
        default:     valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_me) begin
      unique case (wr_mode_i)
        MODE_LOOKUP: stamp_q <= wr_now_i;
        MODE_INSERT: begin
          key_q    <= wr_key_i;
          status_q <= wr_status_i;
          stamp_q  <= wr_now_i;
        end
        default: ;
      endcase
    end
  end

  assign ctl_o  = ctl_q;
  assign key_o  = tkey_q;
  assign now_o  = tnow_q;
  assign slot_o = slot_q;
  assign age_o  = age_q;
  assign st_o   = st_q;

endmodule

`default_nettype wire

>>> hw/rtl/expiring_status_cache_core.sv
// Top level of the expiring status cache: control, result register, cell chain.
// Depends on esc_pkg and esc_cell.
//
// Use:
//  - Request channel (in_valid_i / in_ready_o) carries mode_i, path_key_i,
//    status_in_i and now_i. Modes: lookup, insert, invalidate; the unused
//    code answers with hit 0, slot 0 and changes nothing.
//  - Response channel (out_valid_o / out_ready_i) gives one beat per request:
//    hit_o, status_out_o, slot_o.
//  - cfg_we_i / cfg_wdata_i write the expiry age; only while idle.
//  - One request in flight. A request beat walks a token through the chain
//    of ENTRIES cells, one cell per cycle, then a write-back step follows
//    where the chosen entry is refreshed, filled or cleared.
//  - in_ready_o is high only while idle, so the next request is taken only
//    after the write-back of the request before it has been done. The chain
//    length sets how long the scan of each request lasts.
//  - A stalled receiver holds the response register; the block can scan a
//    new request meanwhile but waits at write-back until the old beat is taken.
//  - Reset clears every valid mark, the expiry register to 30, the response
//    channel and the control state. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module expiring_status_cache_core import esc_pkg::*; #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned STATUS_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              mode_i,
  input  wire logic [KEY_BITS-1:0]     path_key_i,
  input  wire logic [STATUS_BITS-1:0]  status_in_i,
  input  wire logic [TIME_W-1:0]       now_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         hit_o,
  output logic [STATUS_OUT_W-1:0]      status_out_o,
  output logic [SLOT_W-1:0]            slot_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  state_e state_q, state_d;

  logic [CFG_W-1:0] expiry_q;

  // request held for the whole scan and the write-back
  mode_e                  mode_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [STATUS_BITS-1:0] status_q;
  logic [TIME_W-1:0]      now_q;
  logic                   head_vld_q;

  // scan result captured from the chain tail
  logic                   res_found_q;
  logic [IDX_W-1:0]       res_slot_q;
  logic [STATUS_BITS-1:0] res_st_q;

  // response register
  logic                   out_vld_q;
  logic                   hit_q;
  logic [STATUS_OUT_W-1:0] st_out_q;
  logic [SLOT_W-1:0]      slot_out_q;

  logic launch, capture, finish, out_free, wr_en;

  // token chain, stage 0 is the head driven from here
  scan_ctrl_t             ctl_s  [ENTRIES+1];
  logic [KEY_BITS-1:0]    key_s  [ENTRIES+1];
  logic [TIME_W-1:0]      now_s  [ENTRIES+1];
  logic [IDX_W-1:0]       slot_s [ENTRIES+1];
  logic [TIME_W-1:0]      age_s  [ENTRIES+1];
  logic [STATUS_BITS-1:0] st_s   [ENTRIES+1];

  // ---------------------------------------------------------------- control
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i)          state_d = ST_SCAN;
      ST_SCAN: if (ctl_s[ENTRIES].vld) state_d = ST_DONE;
      ST_DONE: if (out_free)            state_d = ST_IDLE;
      default:                          state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    launch     = in_valid_i && (state_q == ST_IDLE);
    capture    = (state_q == ST_SCAN) && ctl_s[ENTRIES].vld;
    finish     = (state_q == ST_DONE) && out_free;
    wr_en      = finish && ((mode_q == MODE_INSERT) || res_found_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_vld_q <= 1'b0;
      expiry_q   <= EXPIRY_RESET;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_vld_q <= launch;
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
      priority if (finish) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      mode_q   <= mode_e'(mode_i);
      key_q    <= path_key_i;
      status_q <= status_in_i;
      now_q    <= now_i;
    end
    if (capture) begin
      res_found_q <= ctl_s[ENTRIES].found;
      res_slot_q  <= slot_s[ENTRIES];
      res_st_q    <= st_s[ENTRIES];
    end
    if (finish) begin
      hit_q      <= (mode_q == MODE_INSERT) || res_found_q;
      st_out_q   <= STATUS_OUT_W'(res_st_q);
      slot_out_q <= SLOT_W'(res_slot_q);
    end
  end

  // ------------------------------------------------------------- cell chain
  assign ctl_s[0]  = '{vld: head_vld_q, mode: mode_q, found: 1'b0, free_found: 1'b0};
  assign key_s[0]  = key_q;
  assign now_s[0]  = now_q;
  assign slot_s[0] = '0;
  assign age_s[0]  = '0;
  assign st_s[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    esc_cell #(
      .KEY_BITS    (KEY_BITS),
      .STATUS_BITS (STATUS_BITS),
      .IDX_W       (IDX_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .expiry_i    (expiry_q),
      .ctl_i       (ctl_s[i]),
      .key_i       (key_s[i]),
      .now_i       (now_s[i]),
      .slot_i      (slot_s[i]),
      .age_i       (age_s[i]),
      .st_i        (st_s[i]),
      .ctl_o       (ctl_s[i+1]),
      .key_o       (key_s[i+1]),
      .now_o       (now_s[i+1]),
      .slot_o      (slot_s[i+1]),
      .age_o       (age_s[i+1]),
      .st_o        (st_s[i+1]),
      .wr_en_i     (wr_en),
      .wr_mode_i   (mode_q),
      .wr_slot_i   (res_slot_q),
      .wr_key_i    (key_q),
      .wr_status_i (status_q),
      .wr_now_i    (now_q)
    );
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid_o  = out_vld_q;
  assign hit_o        = hit_q;
  assign status_out_o = st_out_q;
  assign slot_o       = slot_out_q;

endmodule

`default_nettype wire

>>> hw/rtl/esc_checker.sv
// Port-level checks for the expiring status cache, bound to the top level.
// Depends on esc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module esc_checker import esc_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic                    hit_o,
  input wire logic [STATUS_OUT_W-1:0] status_out_o,
  input wire logic [SLOT_W-1:0]       slot_o
);

  // response beat waiting on the receiver
  logic stalled;

  assign stalled = out_valid_o && !out_ready_i;

  `ESC_ASSERT(a_out_hold, stalled |=> out_valid_o, "response beat dropped")
  `ESC_ASSERT(a_out_stable, stalled |=> $stable({hit_o, slot_o, status_out_o}), "stalled beat changed")
  `ESC_ASSERT(a_status_needs_hit, out_valid_o && (status_out_o != '0) |-> hit_o, "status without hit")
  `ESC_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o, "second request taken")
  `ESC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "response valid in reset")

endmodule

bind expiring_status_cache_core esc_checker u_esc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hit_o        (hit_o),
  .status_out_o (status_out_o),
  .slot_o       (slot_o)
);

`default_nettype wire
